// File: design/dsma_pkg.sv
// dsma_pkg: shared types and constants for the dual moving average core
// command and status structs between controller and datapath, register indexes
// no dependencies
package dsma_pkg;

    // stream payload widths (fixed by the field list)
    localparam int SAMPLE_IN_W = 32;
    localparam int AVG_W       = 32;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_PERIOD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PERIOD  = 1'b1;

    localparam logic [CFG_DATA_W-1:0] SHORT_PERIOD_RST = 7'd5;
    localparam logic [CFG_DATA_W-1:0] LONG_PERIOD_RST  = 7'd20;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch sample, apply restart
        logic rd_short;   // read ring entry leaving the short window
        logic rd_long;    // read ring entry leaving the long window
        logic upd_short;  // slide short sum
        logic upd_long;   // slide long sum, write ring, advance pointers
        logic div_start;  // start both dividers
        logic out_load;   // load output register
    } t_dsma_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;   // both quotients ready
        logic out_free;   // output register can take a result
    } t_dsma_sts;

endpackage

// File: design/dsma_div.sv
// dsma_div: restoring divider, one quotient bit per cycle
// divides a running window sum by a window period; no package dependencies
module dsma_div #(
    parameter int DIVIDEND_W = 38,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0]    trial;
    logic                  take;
    logic [DIVISOR_W:0]    diff;

    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign take  = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], take};
            r_rem <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    // done is raised during the final step; the quotient is complete once that step is registered
    assign o_done     = r_busy && (r_cnt == CNT_W'(DIVIDEND_W - 1));
    assign o_quotient = r_quo;

endmodule

// File: design/dsma_ctrl.sv
// dsma_ctrl: sequencing state machine for one sample transaction
// uses dsma_pkg for the command and status structs
module dsma_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  dsma_pkg::t_dsma_sts i_sts,
    output dsma_pkg::t_dsma_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD_S  = 3'd1;
    localparam logic [2:0] ST_RD_L  = 3'd2;
    localparam logic [2:0] ST_UPD_L = 3'd3;
    localparam logic [2:0] ST_START = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_s_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RD_S;
                end
            end
            ST_RD_S: begin
                o_cmd.rd_short = 1'b1;
                n_state        = ST_RD_L;
            end
            ST_RD_L: begin
                o_cmd.rd_long   = 1'b1;
                o_cmd.upd_short = 1'b1;
                n_state         = ST_UPD_L;
            end
            ST_UPD_L: begin
                o_cmd.upd_long = 1'b1;
                n_state        = ST_START;
            end
            ST_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == ST_RD_S))
        else $error("accepted transaction did not start the read sequence");

    a_out_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("output register loaded while still holding a result");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_div_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> !i_sts.div_done)
        else $error("divider reported done right after start");

endmodule

// File: design/dsma_datapath.sv
// dsma_datapath: sample ring, running window sums, dividers and output register
// uses dsma_pkg for command/status structs and constants, instantiates dsma_div
module dsma_datapath #(
    parameter int MAX_PERIOD   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dsma_pkg::t_dsma_cmd                 i_cmd,
    output dsma_pkg::t_dsma_sts                 o_sts,
    input  logic [dsma_pkg::SAMPLE_IN_W-1:0]    i_sample,
    input  logic                                i_restart,
    input  logic                                i_cfg_valid,
    input  logic [dsma_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [dsma_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [dsma_pkg::AVG_W-1:0]          o_short_average,
    output logic                                o_short_valid,
    output logic [dsma_pkg::AVG_W-1:0]          o_long_average,
    output logic                                o_long_valid
);

    localparam int PTR_W = $clog2(MAX_PERIOD);
    localparam int PER_W = $clog2(MAX_PERIOD + 1);
    localparam int IDX_W = PER_W + 1;
    localparam int SUM_W = SAMPLE_WIDTH + PER_W;
    localparam int AVG_W = dsma_pkg::AVG_W;

    function automatic logic [PER_W-1:0] clamp_period(input logic [dsma_pkg::CFG_DATA_W-1:0] p);
        int v;
        begin
            v = int'(p);
            if (v < 1) begin
                v = 1;
            end else if (v > MAX_PERIOD) begin
                v = MAX_PERIOD;
            end
            clamp_period = PER_W'(v);
        end
    endfunction

    // ring slot that drops out of a window of length p
    function automatic logic [PTR_W-1:0] tail_slot(input logic [PTR_W-1:0] wp,
                                                   input logic [PER_W-1:0] p);
        logic [IDX_W-1:0] t;
        begin
            t = IDX_W'(wp) + IDX_W'(MAX_PERIOD) - IDX_W'(p);
            if (t >= IDX_W'(MAX_PERIOD)) begin
                t = t - IDX_W'(MAX_PERIOD);
            end
            tail_slot = t[PTR_W-1:0];
        end
    endfunction

    logic [dsma_pkg::CFG_DATA_W-1:0] r_short_cfg;
    logic [dsma_pkg::CFG_DATA_W-1:0] r_long_cfg;
    logic [PTR_W-1:0]        r_wp;
    logic [PER_W-1:0]        r_fill;
    logic [SUM_W-1:0]        r_short_sum;
    logic [SUM_W-1:0]        r_long_sum;
    logic [SAMPLE_WIDTH-1:0] r_x;
    logic [SAMPLE_WIDTH-1:0] r_hist [MAX_PERIOD];
    logic [SAMPLE_WIDTH-1:0] r_rd_data;
    logic                    r_out_valid;
    logic [AVG_W-1:0]        r_short_avg;
    logic [AVG_W-1:0]        r_long_avg;
    logic                    r_short_ok;
    logic                    r_long_ok;

    logic [PER_W-1:0]                  ps;
    logic [PER_W-1:0]                  pl;
    logic [PTR_W-1:0]                  rd_addr;
    logic [SAMPLE_WIDTH+dsma_pkg::SAMPLE_IN_W-1:0] sample_ext;
    logic [SUM_W-1:0]                  n_short_sum;
    logic [SUM_W-1:0]                  n_long_sum;
    logic                              short_div_done;
    logic                              long_div_done;
    logic [SUM_W-1:0]                  short_quo;
    logic [SUM_W-1:0]                  long_quo;
    logic [SUM_W+AVG_W-1:0]            short_quo_ext;
    logic [SUM_W+AVG_W-1:0]            long_quo_ext;
    logic                              sv;
    logic                              lv;
    logic                              cfg_write;

    assign ps         = clamp_period(r_short_cfg);
    assign pl         = clamp_period(r_long_cfg);
    assign sample_ext = {{SAMPLE_WIDTH{1'b0}}, i_sample};
    assign cfg_write  = i_cfg_valid;

    assign rd_addr = i_cmd.rd_short ? tail_slot(r_wp, ps) : tail_slot(r_wp, pl);

    // slide: drop the oldest entry once the window is full, then add the new one
    assign n_short_sum = ((r_fill >= ps) ? (r_short_sum - SUM_W'(r_rd_data)) : r_short_sum)
                         + SUM_W'(r_x);
    assign n_long_sum  = ((r_fill >= pl) ? (r_long_sum - SUM_W'(r_rd_data)) : r_long_sum)
                         + SUM_W'(r_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_cfg <= dsma_pkg::SHORT_PERIOD_RST;
            r_long_cfg  <= dsma_pkg::LONG_PERIOD_RST;
            r_wp        <= '0;
            r_fill      <= '0;
            r_short_sum <= '0;
            r_long_sum  <= '0;
        end else if (cfg_write) begin
            case (i_cfg_index)
                dsma_pkg::CFG_SHORT_PERIOD: r_short_cfg <= i_cfg_data;
                dsma_pkg::CFG_LONG_PERIOD:  r_long_cfg  <= i_cfg_data;
                default: ;
            endcase
            r_fill      <= '0;
            r_short_sum <= '0;
            r_long_sum  <= '0;
        end else begin
            if (i_cmd.load && i_restart) begin
                r_fill      <= '0;
                r_short_sum <= '0;
                r_long_sum  <= '0;
            end
            if (i_cmd.upd_short) begin
                r_short_sum <= n_short_sum;
            end
            if (i_cmd.upd_long) begin
                r_long_sum <= n_long_sum;
                r_wp       <= (r_wp == PTR_W'(MAX_PERIOD - 1)) ? '0 : r_wp + 1'b1;
                if (r_fill < PER_W'(MAX_PERIOD)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= sample_ext[SAMPLE_WIDTH-1:0];
        end
    end

    // sample ring: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_long) begin
            r_hist[r_wp] <= r_x;
        end
        if (i_cmd.rd_short || i_cmd.rd_long) begin
            r_rd_data <= r_hist[rd_addr];
        end
    end

    dsma_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (PER_W)
    ) u_short_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_short_sum),
        .i_divisor  (ps),
        .o_done     (short_div_done),
        .o_quotient (short_quo)
    );

    dsma_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (PER_W)
    ) u_long_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_long_sum),
        .i_divisor  (pl),
        .o_done     (long_div_done),
        .o_quotient (long_quo)
    );

    assign short_quo_ext = {{AVG_W{1'b0}}, short_quo};
    assign long_quo_ext  = {{AVG_W{1'b0}}, long_quo};

    // fill count is already advanced for this sample
    assign sv = (r_fill >= ps);
    assign lv = (r_fill >= pl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_short_avg <= sv ? short_quo_ext[AVG_W-1:0] : '0;
            r_long_avg  <= lv ? long_quo_ext[AVG_W-1:0] : '0;
            r_short_ok  <= sv;
            r_long_ok   <= lv;
        end
    end

    assign o_sts.div_done = short_div_done & long_div_done;
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid      = r_out_valid;
    assign o_short_average = r_short_avg;
    assign o_short_valid   = r_short_ok;
    assign o_long_average  = r_long_avg;
    assign o_long_valid    = r_long_ok;

endmodule

// File: design/dual_simple_moving_average_core.sv
// dual_simple_moving_average_core: top level of the dual moving average block
// depends on dsma_pkg, dsma_ctrl, dsma_datapath (and dsma_div below it)
//
// Each sample transaction on the slave stream (UQ16.16 price in tdata, restart
// flag in tuser) yields exactly one result transaction carrying a short-window
// and a long-window mean, each truncated, together with a valid flag; an
// average reads zero until its period's worth of samples has arrived in the
// current series. The block handles one sample at a time: after acceptance it
// reads the sample ring for each window, updates the two sums, starts the
// dividers, waits for both quotients and loads the output register, and the
// next sample is taken in the cycle after the result is loaded. The running
// sums are SUM_W = SAMPLE_WIDTH + clog2(MAX_PERIOD+1) bits wide; the two
// restoring dividers run side by side and produce one quotient bit per cycle.
// A finished result waits in the output register while the next sample is
// accepted; if it is still waiting when the next result is ready, the input
// stalls until it is taken. Writing either period register restarts the
// series; period writes are taken only while the block is idle and no sample
// is offered.
module dual_simple_moving_average_core #(
    parameter int MAX_PERIOD   = 64,   // ring depth, largest usable period
    parameter int SAMPLE_WIDTH = 32    // sample bits kept, upper bits ignored
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // sample stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] sample
    input  logic [0:0]  i_s_tuser,   // [0] restart

    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [31:0] short_average, [63:32] long_average
    output logic [1:0]  o_m_tuser,   // [0] short_valid, [1] long_valid

    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index, // 0 short_period, 1 long_period
    input  logic [6:0]  i_cfg_data
);

    dsma_pkg::t_dsma_cmd cmd;
    dsma_pkg::t_dsma_sts sts;

    logic [31:0] short_average;
    logic [31:0] long_average;
    logic        short_valid;
    logic        long_valid;
    logic        cfg_accept;

    // period writes land only while the controller is idle and no sample is offered,
    // so a write never meets a transaction in flight
    assign o_cfg_ready = o_s_tready & ~i_s_tvalid;
    assign cfg_accept  = i_cfg_valid & o_cfg_ready;

    // sequencing: accept, two ring reads, sum updates, divide, output
    dsma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // ring, running sums, dividers and output register
    dsma_datapath #(
        .MAX_PERIOD   (MAX_PERIOD),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_sample        (i_s_tdata),
        .i_restart       (i_s_tuser[0]),
        .i_cfg_valid     (cfg_accept),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_m_tready      (i_m_tready),
        .o_m_tvalid      (o_m_tvalid),
        .o_short_average (short_average),
        .o_short_valid   (short_valid),
        .o_long_average  (long_average),
        .o_long_valid    (long_valid)
    );

    // pack result fields, first field in the low bits
    assign o_m_tdata = {long_average, short_average};
    assign o_m_tuser = {long_valid, short_valid};

endmodule

// File: sim/dual_simple_moving_average_core_test.sv
// dual_simple_moving_average_core_test: self-checking bench for the dual moving average core
// directed table, then random phases; results checked by hand-derived values or a predictor
// depends on dsma_pkg and dual_simple_moving_average_core
module dual_simple_moving_average_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AVG_W        = dsma_pkg::AVG_W;
    localparam int CFG_INDEX_W  = dsma_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W   = dsma_pkg::CFG_DATA_W;
    localparam int SAMPLE_IN_W  = dsma_pkg::SAMPLE_IN_W;

    localparam int RING_DEPTH   = 64;    // matches MAX_PERIOD of the instance
    localparam int STALL_LIMIT  = 3000;  // cycles with no transaction on any channel
    localparam int HOLD_AFTER   = 400;   // results taken before the long back-pressure stretch
    localparam int HOLD_CYCLES  = 600;   // length of that stretch
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 160;
    localparam int DRAIN_CYCLES = 60;    // beyond the sample-to-result latency
    localparam int PRINT_LIMIT  = 40;

    // one result transaction, split into its fields
    typedef struct packed {
        logic [AVG_W-1:0] short_avg;
        logic             short_ok;
        logic [AVG_W-1:0] long_avg;
        logic             long_ok;
    } t_averages;

    typedef enum logic {ROW_CONFIG, ROW_SAMPLE} t_row_kind;

    // one line of the directed stimulus
    typedef struct {
        t_row_kind              kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        logic [SAMPLE_IN_W-1:0] sample;
        logic                   restart;
        bit                     known;    // want holds a hand-derived result
        t_averages              want;
    } t_stim_row;

    logic                   clk;
    logic                   rst_n;

    logic                   s_tvalid;
    logic                   s_tready;
    logic [SAMPLE_IN_W-1:0] s_tdata;
    logic [0:0]             s_tuser;

    logic                   m_tvalid;
    logic                   m_tready;
    logic [2*AVG_W-1:0]     m_tdata;
    logic [1:0]             m_tuser;

    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    dual_simple_moving_average_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),     // [31:0] sample
        .i_s_tuser   (s_tuser),     // [0] restart
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),     // [31:0] short_average, [63:32] long_average
        .o_m_tuser   (m_tuser),     // [0] short_valid, [1] long_valid
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),   // 0 short_period, 1 long_period
        .i_cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5ns clk = ~clk;

    // ------------------------------------------------------------------
    // predictor state: sample ring, write slot, series length, window sums
    // ------------------------------------------------------------------
    logic [SAMPLE_IN_W-1:0] ring [RING_DEPTH];
    logic [5:0]             ring_wp;
    logic [6:0]             series_len;   // saturates at the ring depth
    logic [37:0]            short_sum;
    logic [37:0]            long_sum;
    logic [CFG_DATA_W-1:0]  short_len;    // raw register values, clamped on use
    logic [CFG_DATA_W-1:0]  long_len;

    t_averages  pending_averages [$];   // results owed by the block, oldest first
    t_stim_row  stim_rows [$];
    int         mismatches;
    int         results_seen;
    int         idle_run [2];           // remaining gap-free items, sender and receiver

    // zero acts as one, anything past the ring depth as the ring depth
    function automatic logic [6:0] effective_period(input logic [CFG_DATA_W-1:0] p);
        if (p == 0)
            return 7'd1;
        if (p > RING_DEPTH)
            return 7'(RING_DEPTH);
        return p;
    endfunction

    // restart and register writes drop the series but keep the write slot running
    function automatic void clear_series();
        series_len = '0;
        short_sum  = '0;
        long_sum   = '0;
    endfunction

    // advance the predictor by one accepted sample and return the averages it yields
    function automatic t_averages predict_averages(input logic [SAMPLE_IN_W-1:0] x,
                                                   input logic restart);
        logic [6:0] ps;
        logic [6:0] pl;
        logic [5:0] short_old;
        logic [5:0] long_old;
        t_averages  r;
        ps = effective_period(short_len);
        pl = effective_period(long_len);
        if (restart)
            clear_series();
        // the sample leaving each window sits one period behind the write slot
        short_old = ring_wp - ps[5:0];
        long_old  = ring_wp - pl[5:0];
        if (series_len >= ps)
            short_sum = short_sum - {6'd0, ring[short_old]};
        if (series_len >= pl)
            long_sum = long_sum - {6'd0, ring[long_old]};
        short_sum = short_sum + {6'd0, x};
        long_sum  = long_sum + {6'd0, x};
        ring[ring_wp] = x;
        ring_wp = ring_wp + 6'd1;
        if (series_len < RING_DEPTH)
            series_len = series_len + 7'd1;
        r.short_ok  = series_len >= ps;
        r.long_ok   = series_len >= pl;
        r.short_avg = r.short_ok ? AVG_W'(short_sum / {31'd0, ps}) : '0;
        r.long_avg  = r.long_ok ? AVG_W'(long_sum / {31'd0, pl}) : '0;
        return r;
    endfunction

    // gap before the next transaction on one side, with gap-free runs now and then
    function automatic int pick_gap(input int side);
        if (idle_run[side] > 0) begin
            idle_run[side]--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            idle_run[side] = $urandom_range(10, 40);
        return $urandom_range(0, 11);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch on %s at result %0d: got %h, expected %h",
                     field, results_seen, got, want);
    endtask

    // ------------------------------------------------------------------
    // directed table builders
    // ------------------------------------------------------------------
    task automatic add_config(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
        t_stim_row row;
        row = '{kind: ROW_CONFIG, reg_index: idx, reg_value: value, sample: '0,
                restart: 1'b0, known: 1'b0, want: '0};
        stim_rows.push_back(row);
    endtask

    task automatic add_sample(input logic [SAMPLE_IN_W-1:0] x, input logic restart);
        t_stim_row row;
        row = '{kind: ROW_SAMPLE, reg_index: '0, reg_value: '0, sample: x,
                restart: restart, known: 1'b0, want: '0};
        stim_rows.push_back(row);
    endtask

    task automatic add_known(input logic [SAMPLE_IN_W-1:0] x, input logic restart,
                             input logic [AVG_W-1:0] sa, input logic sv,
                             input logic [AVG_W-1:0] la, input logic lv);
        t_stim_row row;
        t_averages w;
        w.short_avg = sa;
        w.short_ok  = sv;
        w.long_avg  = la;
        w.long_ok   = lv;
        row = '{kind: ROW_SAMPLE, reg_index: '0, reg_value: '0, sample: x,
                restart: restart, known: 1'b1, want: w};
        stim_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // bus tasks, entered and left at a falling edge
    // ------------------------------------------------------------------

    // one sample transaction; valid stays high into the next item when no gap is drawn
    task automatic send_sample(input logic [SAMPLE_IN_W-1:0] x, input logic restart,
                               input bit known, input t_averages want);
        int        gap;
        t_averages predicted;
        gap = pick_gap(0);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = x;
        s_tuser  = restart;
        do @(posedge clk); while (!s_tready);
        // predictor always advances, even when the row carries its own result
        predicted = predict_averages(x, restart);
        pending_averages.push_back(known ? want : predicted);
        @(negedge clk);
    endtask

    // register write once every owed result has come back
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        s_tvalid = 1'b0;
        while (pending_averages.size() != 0)
            @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == dsma_pkg::CFG_SHORT_PERIOD)
            short_len = value;
        else
            long_len = value;
        clear_series();
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, one long hold-off, field-by-field checks
    // ------------------------------------------------------------------
    initial begin : result_side
        int        gap;
        t_averages want;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            // long back-pressure while the sender keeps offering samples
            if (results_seen == HOLD_AFTER) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = pick_gap(1);
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            results_seen++;
            if (pending_averages.size() == 0) begin
                report_mismatch("unrequested result", m_tdata[31:0], '0);
            end else begin
                want = pending_averages.pop_front();
                if (m_tdata[31:0] !== want.short_avg)
                    report_mismatch("short_average", m_tdata[31:0], want.short_avg);
                if (m_tuser[0] !== want.short_ok)
                    report_mismatch("short_valid", {31'd0, m_tuser[0]}, {31'd0, want.short_ok});
                if (m_tdata[63:32] !== want.long_avg)
                    report_mismatch("long_average", m_tdata[63:32], want.long_avg);
                if (m_tuser[1] !== want.long_ok)
                    report_mismatch("long_valid", {31'd0, m_tuser[1]}, {31'd0, want.long_ok});
            end
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: any transaction on any channel restarts the count
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [CFG_DATA_W-1:0]  short_cfg;
        logic [CFG_DATA_W-1:0]  long_cfg;
        logic [SAMPLE_IN_W-1:0] x;
        int                     style;
        int                     which;

        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        mismatches   = 0;
        results_seen = 0;
        idle_run[0]  = 0;
        idle_run[1]  = 0;

        // predictor out of reset
        ring_wp   = '0;
        clear_series();
        short_len = dsma_pkg::SHORT_PERIOD_RST;
        long_len  = dsma_pkg::LONG_PERIOD_RST;

        // directed part: reset periods, period one, zero and oversized periods,
        // restart flag, truncation, extreme samples
        add_known(32'h0001_0000, 1'b0, '0, 1'b0, '0, 1'b0);
        add_config(dsma_pkg::CFG_SHORT_PERIOD, 7'd1);
        add_known(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1, '0, 1'b0);
        add_known(32'h0000_0000, 1'b0, '0, 1'b1, '0, 1'b0);
        add_config(dsma_pkg::CFG_LONG_PERIOD, 7'd1);
        add_known(32'h1234_5678, 1'b1, 32'h1234_5678, 1'b1, 32'h1234_5678, 1'b1);
        add_config(dsma_pkg::CFG_SHORT_PERIOD, 7'd0);
        add_known(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
        add_config(dsma_pkg::CFG_LONG_PERIOD, 7'd127);
        add_known(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1, '0, 1'b0);
        add_config(dsma_pkg::CFG_SHORT_PERIOD, 7'd2);
        add_known(32'd7, 1'b0, '0, 1'b0, '0, 1'b0);
        add_known(32'd8, 1'b0, 32'd7, 1'b1, '0, 1'b0);
        add_known(32'd5, 1'b1, '0, 1'b0, '0, 1'b0);
        add_sample(32'd6, 1'b0);
        add_config(dsma_pkg::CFG_SHORT_PERIOD, 7'd65);
        add_config(dsma_pkg::CFG_LONG_PERIOD, 7'd3);
        add_sample(32'hFFFF_FFFF, 1'b1);
        add_sample(32'h8000_0000, 1'b0);
        add_sample(32'h0000_0001, 1'b0);
        add_sample(32'hFFFF_FFFF, 1'b0);

        // synchronous reset, released at a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CONFIG)
                write_register(stim_rows[i].reg_index, stim_rows[i].reg_value);
            else
                send_sample(stim_rows[i].sample, stim_rows[i].restart,
                            stim_rows[i].known, stim_rows[i].want);
        end

        // random phases: extreme period pairs first, then random ones
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin short_cfg = 7'd1;   long_cfg = 7'd64; end
                1: begin short_cfg = 7'd64;  long_cfg = 7'd1;  end
                2: begin short_cfg = 7'd0;   long_cfg = 7'd127; end
                3: begin short_cfg = 7'd127; long_cfg = 7'd0;  end
                4: begin short_cfg = 7'd64;  long_cfg = 7'd64; end
                default: begin
                    short_cfg = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                           : 7'($urandom_range(1, 64));
                    long_cfg  = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                           : 7'($urandom_range(1, 64));
                end
            endcase
            // later phases sometimes rewrite only one of the two periods
            which = (phase < 5) ? 0 : $urandom_range(0, 2);
            if (which != 2)
                write_register(dsma_pkg::CFG_SHORT_PERIOD, short_cfg);
            if (which != 1)
                write_register(dsma_pkg::CFG_LONG_PERIOD, long_cfg);

            // sample mix: full-range, mostly all-ones (largest sums), small values
            style = phase % 3;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case (style)
                    0: x = $urandom;
                    1: x = ($urandom_range(0, 3) != 0) ? 32'hFFFF_FFFF : 32'($urandom);
                    default: x = ($urandom_range(0, 4) == 0) ? 32'd0
                                                            : 32'($urandom_range(0, 255));
                endcase
                send_sample(x, ($urandom_range(0, 39) == 0), 1'b0, '0);
            end
        end
        s_tvalid = 1'b0;

        // drain, then give the block time to show any stray result
        while (pending_averages.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_averages.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: dual_simple_moving_average_core.f
design/dsma_pkg.sv
design/dsma_div.sv
design/dsma_ctrl.sv
design/dsma_datapath.sv
design/dual_simple_moving_average_core.sv
sim/dual_simple_moving_average_core_test.sv
